[rtl/assert_macros.svh]
// Assertion macros, included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lfu_scp_pkg.sv]
// Shared codes and controller/datapath interface types for the LFU cache directory.
`timescale 1ns / 1ps
package lfu_scp_pkg;

    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_PLACE = 2'd2;

    localparam logic [2:0] OUT_HIT   = 3'd0;
    localparam logic [2:0] OUT_MISS  = 3'd1;
    localparam logic [2:0] OUT_NONE  = 3'd2;
    localparam logic [2:0] OUT_CLEAN = 3'd3;
    localparam logic [2:0] OUT_DIRTY = 3'd4;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic look;
        logic bubble;
        logic wb;
        logic out_load;
    } lfu_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic split_done;
        logic is_place;
        logic hit;
        logic need_bubble;
    } lfu_sts_t;

endpackage

[rtl/lfu_scp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lfu_scp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[rtl/lfu_scp_div.sv]
// Divider by a constant: shift for powers of two, else a pipelined reciprocal multiply.
`timescale 1ns / 1ps
module lfu_scp_div #(
    parameter int WIDTH   = 32,
    parameter int DIVISOR = 64,
    parameter int RW      = ($clog2(DIVISOR) > 0) ? $clog2(DIVISOR) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start_i,
    input  logic [WIDTH-1:0] dividend_i,
    output logic             done_o,
    output logic [WIDTH-1:0] quot_o,
    output logic [RW-1:0]    rem_o
);
    localparam bit POW2 = ((DIVISOR & (DIVISOR - 1)) == 0);

    generate
        if (POW2) begin : g_shift
            localparam int SH = $clog2(DIVISOR);
            logic             done_reg;
            logic [WIDTH-1:0] quot_reg;
            logic [RW-1:0]    rem_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start_i;
                    if (start_i) begin
                        quot_reg <= dividend_i >> SH;
                        rem_reg  <= RW'(dividend_i & WIDTH'(DIVISOR - 1));
                    end
                end
            end
            assign done_o = done_reg;
            assign quot_o = quot_reg;
            assign rem_o  = rem_reg;
        end else begin : g_recip
            // q = (x * M) >> (WIDTH + L), M = floor(2^(WIDTH+L) / d) + 1, exact for all x
            localparam int L  = $clog2(DIVISOR);
            localparam int SH = WIDTH + L;
            localparam int MW = WIDTH + 1;
            localparam int HW = WIDTH / 2;
            localparam int LW = HW + MW;
            localparam int UW = WIDTH - HW + MW;
            localparam int SW = UW + HW + 1;
            localparam longint unsigned MUL_FULL = ((64'd1 << SH) / DIVISOR) + 1;
            localparam logic [MW-1:0] MUL = MW'(MUL_FULL);

            logic [2:0]       step_reg;
            logic [WIDTH-1:0] num_reg;
            logic [LW-1:0]    lo_reg;
            logic [UW-1:0]    hi_reg;
            logic [WIDTH-1:0] quot_reg;
            logic [RW-1:0]    rem_reg;
            logic [SW-1:0]    sum;

            // halves of the product, one multiply each
            assign sum = SW'({hi_reg, {HW{1'b0}}}) + SW'(lo_reg);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    step_reg <= '0;
                end else begin
                    step_reg <= {step_reg[1:0], start_i};
                end
            end

            always_ff @(posedge aclk) begin
                if (start_i) begin
                    num_reg <= dividend_i;
                    lo_reg  <= dividend_i[HW-1:0] * MUL;
                    hi_reg  <= dividend_i[WIDTH-1:HW] * MUL;
                end
                if (step_reg[0]) begin
                    quot_reg <= WIDTH'(sum >> SH);
                end
                if (step_reg[1]) begin
                    rem_reg <= RW'(num_reg - WIDTH'(quot_reg * WIDTH'(DIVISOR)));
                end
            end
            assign done_o = step_reg[2];
            assign quot_o = quot_reg;
            assign rem_o  = rem_reg;
        end
    endgenerate
endmodule

[rtl/lfu_scp_ctrl.sv]
// Controller FSM: clearing pass, request sequencing and result handoff.
`timescale 1ns / 1ps
module lfu_scp_ctrl import lfu_scp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output lfu_cmd_t cmd,
    input  lfu_sts_t sts
);
    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_SPLIT, ST_READ, ST_LOOK, ST_BUBBLE, ST_WB, ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                if (sts.split_done) state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_LOOK;
            end
            ST_LOOK: begin
                cmd.look = 1'b1;
                priority if (sts.is_place) state_next = ST_WB;
                else if (sts.hit)          state_next = ST_BUBBLE;
                else                       state_next = ST_DONE;
            end
            ST_BUBBLE: begin
                if (sts.need_bubble) cmd.bubble = 1'b1;
                else                 state_next = ST_WB;
            end
            ST_WB: begin
                cmd.wb     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end
endmodule

[rtl/lfu_scp_dp.sv]
// Datapath: address split, set row storage, lookup, insert and count reorder.
`timescale 1ns / 1ps
module lfu_scp_dp import lfu_scp_pkg::*; #(
    parameter int WAYS        = 4,
    parameter int SETS        = 64,
    parameter int BLOCK_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  lfu_cmd_t    cmd,
    output lfu_sts_t    sts,
    input  logic [1:0]  act_i,
    input  logic [31:0] addr_i,
    input  logic        dirty_i,
    output logic [2:0]  outcome_o
);
    localparam int SET_W = ($clog2(SETS) > 0) ? $clog2(SETS) : 1;
    localparam int WAY_W = ($clog2(WAYS) > 0) ? $clog2(WAYS) : 1;
    localparam longint unsigned TAG_MAX = 64'hFFFF_FFFF / BLOCK_BYTES / SETS;
    localparam int TAG_W = (TAG_MAX > 0) ? $clog2(TAG_MAX + 1) : 1;
    localparam int ENT_W = 2 + TAG_W + COUNT_W;
    localparam int ROW_W = WAYS * ENT_W;

    logic [1:0]       act_reg;
    logic             dirty_in_reg;
    logic [SET_W-1:0] clr_reg;
    logic [WAY_W-1:0] pos_reg;
    logic             hit_reg;
    logic [2:0]       res_reg;
    logic [2:0]       out_reg;

    logic               v_reg [WAYS];
    logic [TAG_W-1:0]   t_reg [WAYS];
    logic [COUNT_W-1:0] c_reg [WAYS];
    logic               d_reg [WAYS];

    logic               rv [WAYS];
    logic [TAG_W-1:0]   rt [WAYS];
    logic [COUNT_W-1:0] rc [WAYS];
    logic               rdb [WAYS];

    logic             done1;
    logic [31:0]      blk;
    logic             done2;
    logic [31:0]      q2;
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag;

    logic [ROW_W-1:0] rdata, wdata;
    logic             hit_any;
    logic [WAY_W-1:0] hit_w;
    logic [WAY_W-1:0] pos_m1;

    lfu_scp_div #(.WIDTH(32), .DIVISOR(BLOCK_BYTES)) u_div_blk (
        .aclk(aclk), .aresetn(aresetn), .start_i(cmd.load), .dividend_i(addr_i),
        .done_o(done1), .quot_o(blk), .rem_o()
    );

    lfu_scp_div #(.WIDTH(32), .DIVISOR(SETS), .RW(SET_W)) u_div_set (
        .aclk(aclk), .aresetn(aresetn), .start_i(done1), .dividend_i(blk),
        .done_o(done2), .quot_o(q2), .rem_o(set_idx)
    );

    assign tag = TAG_W'(q2);

    lfu_scp_ram #(.WIDTH(ROW_W), .DEPTH(SETS), .AW(SET_W)) u_ram (
        .aclk(aclk), .we(cmd.clr_step || cmd.wb),
        .waddr(cmd.clr_step ? clr_reg : set_idx),
        .wdata(cmd.clr_step ? '0 : wdata),
        .raddr(set_idx), .rdata(rdata)
    );

    // Entry layout from the lowest bit: valid, tag, count, dirty.
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            rv[w]  = rdata[w*ENT_W];
            rt[w]  = rdata[w*ENT_W+1 +: TAG_W];
            rc[w]  = rdata[w*ENT_W+1+TAG_W +: COUNT_W];
            rdb[w] = rdata[w*ENT_W+1+TAG_W+COUNT_W];
            wdata[w*ENT_W +: ENT_W] = {d_reg[w], c_reg[w], t_reg[w], v_reg[w]};
        end
    end

    // First valid match from the front wins.
    always_comb begin
        hit_any = 1'b0;
        hit_w   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (rv[w] && (rt[w] == tag)) begin
                hit_any = 1'b1;
                hit_w   = WAY_W'(w);
            end
        end
    end

    assign pos_m1 = pos_reg - 1'b1;

    assign sts.clr_last    = (clr_reg == SET_W'(SETS - 1));
    assign sts.split_done  = done2;
    assign sts.is_place    = (act_reg == ACT_PLACE);
    assign sts.hit         = hit_any;
    assign sts.need_bubble = hit_reg && (pos_reg != '0) && (c_reg[pos_m1] < c_reg[pos_reg]);
    assign outcome_o       = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg      <= act_i;
            dirty_in_reg <= dirty_i;
        end
        if (cmd.look) begin
            if (act_reg == ACT_PLACE) begin
                hit_reg <= 1'b0;
                v_reg[0] <= 1'b1;
                t_reg[0] <= tag;
                c_reg[0] <= '0;
                d_reg[0] <= dirty_in_reg;
                for (int w = 1; w < WAYS; w++) begin
                    v_reg[w] <= rv[w-1];
                    t_reg[w] <= rt[w-1];
                    c_reg[w] <= rc[w-1];
                    d_reg[w] <= rdb[w-1];
                end
                if (rv[WAYS-1]) res_reg <= rdb[WAYS-1] ? OUT_DIRTY : OUT_CLEAN;
                else            res_reg <= OUT_NONE;
            end else begin
                hit_reg <= hit_any;
                pos_reg <= hit_w;
                for (int w = 0; w < WAYS; w++) begin
                    v_reg[w] <= rv[w];
                    t_reg[w] <= rt[w];
                    c_reg[w] <= rc[w];
                    d_reg[w] <= rdb[w];
                end
                if (hit_any) begin
                    if (rc[hit_w] != COUNT_MAX) c_reg[hit_w] <= rc[hit_w] + 1'b1;
                    if (act_reg == ACT_WRITE)   d_reg[hit_w] <= 1'b1;
                    res_reg <= OUT_HIT;
                end else begin
                    res_reg <= OUT_MISS;
                end
            end
        end
        if (cmd.bubble) begin
            v_reg[pos_m1]   <= v_reg[pos_reg];
            t_reg[pos_m1]   <= t_reg[pos_reg];
            c_reg[pos_m1]   <= c_reg[pos_reg];
            d_reg[pos_m1]   <= d_reg[pos_reg];
            v_reg[pos_reg]  <= v_reg[pos_m1];
            t_reg[pos_reg]  <= t_reg[pos_m1];
            c_reg[pos_reg]  <= c_reg[pos_m1];
            d_reg[pos_reg]  <= d_reg[pos_m1];
            pos_reg         <= pos_m1;
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end
endmodule

[rtl/lfu_set_assoc_cache_policy_top.sv]
// Top level of the set-associative LFU cache directory.
// A request passes split, read and look; a miss then loads the result register, a place
// first writes its set row, and a hit first moves its entry forward one position per
// reorder step and then writes the row. Each divisor (BLOCK_BYTES, SETS) that is not a
// power of two adds reciprocal-multiply steps to the split. One request at a time: the
// input reopens after the result register loads. Reset: synchronous, active low; then a
// clearing pass writes every set row empty, with s_tready low until it ends.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lfu_set_assoc_cache_policy_top import lfu_scp_pkg::*; #(
    parameter int WAYS        = 4,
    parameter int SETS        = 64,
    parameter int BLOCK_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] addr
    input  logic [2:0]  s_tuser,   // [1:0] action, [2] dirty
    // Result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [2:0] outcome, [7:3] zero
);
    lfu_cmd_t   cmd;
    lfu_sts_t   sts;
    logic [2:0] outcome;

    // Sequencer: clearing pass, then split, read, look; hits reorder and write, places write.
    lfu_scp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_tvalid), .s_ready(s_tready),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .cmd(cmd), .sts(sts)
    );

    // Set rows live in one RAM, one row per set, all ways side by side.
    lfu_scp_dp #(.WAYS(WAYS), .SETS(SETS), .BLOCK_BYTES(BLOCK_BYTES)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .sts(sts),
        .act_i(s_tuser[1:0]), .addr_i(s_tdata), .dirty_i(s_tuser[2]),
        .outcome_o(outcome)
    );

    // Result register in the datapath lets a new word in while the last one waits.
    assign m_tdata = {5'd0, outcome};

    `ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second word taken mid-request")
    `ASSERT_NOW(a_outcome_code, m_tvalid, m_tdata[2:0] <= OUT_DIRTY, "outcome code out of range")
    `ASSERT_NOW(a_clear_blocks_input, cmd.clr_step, !s_tready, "input open during clearing pass")
    `ASSERT_NOW(a_bubble_only_on_hit, cmd.bubble, !sts.is_place, "reorder step on a place")
endmodule

[bench/tb_lfu_set_assoc_cache_policy_top.sv]
// LFU cache directory bench: directed and random requests, self-checked by a behavioral predictor.
`timescale 1ns / 1ps
module tb_lfu_set_assoc_cache_policy_top;
    import lfu_scp_pkg::*;

    localparam int WAYS        = 4;
    localparam int SETS        = 64;
    localparam int BLOCK_BYTES = 64;
    localparam int WATCHDOG    = 20000;

    // Predicted outcomes in issue order, checked against result words.
    class outcome_board;
        logic [2:0] pending[$];
        int         errors;

        // per-set ordered entry lists, front at index 0
        logic        vld[SETS][WAYS];
        logic [31:0] tag[SETS][WAYS];
        logic [15:0] cnt[SETS][WAYS];
        logic        drt[SETS][WAYS];

        function new();
            errors = 0;
            foreach (vld[s, w]) begin
                vld[s][w] = 1'b0;
                tag[s][w] = '0;
                cnt[s][w] = '0;
                drt[s][w] = 1'b0;
            end
        endfunction

        function void note_request(logic [1:0] act, logic [31:0] addr, logic dirty_in);
            int          blk, s, n, w;
            logic [31:0] t;
            logic [2:0]  oc;
            logic        tv, td;
            logic [31:0] tt;
            logic [15:0] tc;
            blk = addr / BLOCK_BYTES;
            s = blk % SETS;
            t = blk / SETS;
            n = 0;
            while (n < WAYS && vld[s][n]) n++;
            if (act == ACT_PLACE) begin
                oc = OUT_NONE;
                if (n == WAYS) begin
                    oc = drt[s][WAYS-1] ? OUT_DIRTY : OUT_CLEAN;
                    n = WAYS - 1;
                end
                for (w = n; w > 0; w--) begin
                    vld[s][w] = vld[s][w-1];
                    tag[s][w] = tag[s][w-1];
                    cnt[s][w] = cnt[s][w-1];
                    drt[s][w] = drt[s][w-1];
                end
                vld[s][0] = 1'b1;
                tag[s][0] = t;
                cnt[s][0] = '0;
                drt[s][0] = dirty_in;
            end else begin
                w = 0;
                while (w < n && tag[s][w] != t) w++;
                if (w == n) begin
                    oc = OUT_MISS;
                end else begin
                    if (cnt[s][w] != COUNT_MAX) cnt[s][w]++;
                    while (w > 0 && cnt[s][w-1] < cnt[s][w]) begin
                        tv = vld[s][w-1]; tt = tag[s][w-1];
                        tc = cnt[s][w-1]; td = drt[s][w-1];
                        vld[s][w-1] = vld[s][w]; tag[s][w-1] = tag[s][w];
                        cnt[s][w-1] = cnt[s][w]; drt[s][w-1] = drt[s][w];
                        vld[s][w] = tv; tag[s][w] = tt; cnt[s][w] = tc; drt[s][w] = td;
                        w--;
                    end
                    // action three behaves as a read
                    if (act == ACT_WRITE) drt[s][w] = 1'b1;
                    oc = OUT_HIT;
                end
            end
            pending.push_back(oc);
        endfunction

        function void check_result(logic [7:0] data);
            logic [2:0] exp_oc;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, data);
                errors++;
            end else begin
                exp_oc = pending.pop_front();
                if (data !== {5'b0, exp_oc}) begin
                    $display("%0t: outcome mismatch expected %h actual %h",
                             $time, {5'b0, exp_oc}, data);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;   // [1:0] action, [2] dirty
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [2:0] outcome, [7:3] zero

    outcome_board board;
    int  send_idle;     // percent chance the sender holds back per cycle
    int  recv_stall;    // percent chance the receiver stalls per cycle
    int  quiet_cycles;

    lfu_set_assoc_cache_policy_top #(
        .WAYS(WAYS), .SETS(SETS), .BLOCK_BYTES(BLOCK_BYTES)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    // Result side: random stalls, check every accepted word.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Watchdog: cycles without any accepted word.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("tb_lfu_set_assoc_cache_policy_top: errors");
                $finish;
            end
        end
    end

    // One request word; idle gaps drawn before it, held until accepted.
    task automatic send_request(logic [1:0] act, logic [31:0] addr, logic dirty_in);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        s_tuser  <= {dirty_in, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(act, addr, dirty_in);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    // Address from a small tag pool within a few sets, so sets fill and hit often.
    function automatic logic [31:0] pooled_addr(int set_pool);
        logic [31:0] a;
        a = $urandom();
        a[11:6]  = 6'($urandom_range(set_pool - 1));
        a[14:12] = 3'($urandom_range(7));
        a[31:15] = {16'b0, a[15]} & 17'h1;  // narrow tag pool, top bit still toggles below
        a[31]    = 1'($urandom_range(1));
        return a;
    endfunction

    task automatic random_phase(int items, int idle, int stall);
        logic [1:0] act;
        send_idle  = idle;
        recv_stall = stall;
        repeat (items) begin
            if ($urandom_range(9) < 8) begin
                act = ($urandom_range(9) < 3) ? ACT_PLACE : 2'($urandom_range(3));
                send_request(act, pooled_addr(4), 1'($urandom_range(1)));
            end else begin
                // noise: full-range addresses and actions
                send_request(2'($urandom_range(3)), $urandom(), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        int i;
        board      = new();
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        send_idle  = 0;
        recv_stall = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty misses, fill one set, evict clean and dirty, duplicates, action three.
        send_request(ACT_READ, 32'h0000_0000, 1'b0);
        send_request(ACT_WRITE, 32'hFFFF_FFFF, 1'b1);
        send_request(2'd3, 32'h0000_0040, 1'b0);
        for (i = 0; i < 4; i++) send_request(ACT_PLACE, 32'h0000_1000 * i, i[0]);
        send_request(ACT_PLACE, 32'hFFFF_F000, 1'b0);   // evicts clean back entry
        send_request(ACT_READ, 32'h0000_1000, 1'b0);
        send_request(ACT_WRITE, 32'h0000_1000, 1'b0);
        send_request(2'd3, 32'h0000_2000, 1'b0);
        send_request(ACT_PLACE, 32'hFFFF_F000, 1'b1);   // duplicate tag
        send_request(ACT_READ, 32'hFFFF_F000, 1'b0);
        send_request(ACT_PLACE, 32'h0000_5000, 1'b0);
        send_request(ACT_PLACE, 32'h0000_6000, 1'b0);   // back entry still clean
        send_request(ACT_PLACE, 32'hFFFF_FFC0, 1'b1);   // last set, largest tag
        send_request(ACT_READ, 32'hFFFF_FFC0, 1'b0);
        drain();    // sender holds off until every result is in

        random_phase(250, 0, 0);
        random_phase(200, 71, 0);
        random_phase(200, 0, 71);
        random_phase(250, 15, 15);
        drain();
        repeat (50) @(posedge aclk);

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb_lfu_set_assoc_cache_policy_top: clean");
        end else begin
            $display("tb_lfu_set_assoc_cache_policy_top: errors");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/lfu_scp_pkg.sv
rtl/lfu_scp_ram.sv
rtl/lfu_scp_div.sv
rtl/lfu_scp_ctrl.sv
rtl/lfu_scp_dp.sv
rtl/lfu_set_assoc_cache_policy_top.sv
bench/tb_lfu_set_assoc_cache_policy_top.sv
